// ===== rtl/tes_pkg.sv =====
package tes_pkg;

    localparam int COL_W         = 16;
    localparam int CHAR_W        = 8;
    localparam int CFG_W         = 7;
    localparam int CNT_W         = 3;
    localparam int IDX_W         = 2;
    localparam int REG_IDX_W     = 3;
    localparam int WIDTH_REGS    = 4;
    localparam int MAX_STOPS     = 4;
    localparam int MAX_TAB_WIDTH = 64;
    localparam int STOP_LIMIT    = (MAX_STOPS < WIDTH_REGS) ? MAX_STOPS : WIDTH_REGS;

    localparam logic [CHAR_W-1:0] CHAR_TAB      = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'd32;
    localparam logic [CFG_W-1:0]  DEFAULT_WIDTH = 7'd4;
    localparam logic [CNT_W-1:0]  DEFAULT_COUNT = 3'd1;

    localparam logic [REG_IDX_W-1:0] REG_STOP_COUNT  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TAB_WIDTH_0 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TAB_WIDTH_1 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TAB_WIDTH_2 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_TAB_WIDTH_3 = 3'd4;

    typedef struct packed {
        logic             start;
        logic [COL_W-1:0] dividend;
    } t_rem_req;

endpackage

// ===== rtl/tab_expander_stop_list.sv =====
// channel   signals                                        direction
// request   i_in_valid, o_in_stall, i_in_char, i_line_end   in
// result    o_out_valid, i_out_stall, o_out_char,           out
//           o_run_last, o_line_end_out
// config    i_cfg_we, i_cfg_index, i_cfg_data               in
// a plain byte goes straight to the output register, accepted when idle and the output register is free
// a tab loads the remainder unit, which takes one remainder bit a cycle over the 16 column
// bits; the remainder is then taken and its n spaces go out one a cycle while the output is not stalled
// reset is synchronous; no clearing pass
// a stalled output holds its result; no request is taken until it frees up
module tab_expander_stop_list #(
    parameter int MAX_TAB_WIDTH = tes_pkg::MAX_TAB_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [tes_pkg::CHAR_W-1:0]        i_in_char,
    input  logic                              i_line_end,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [tes_pkg::CHAR_W-1:0]        o_out_char,
    output logic                              o_run_last,
    output logic                              o_line_end_out,
    input  logic                              i_cfg_we,
    input  logic [tes_pkg::REG_IDX_W-1:0]     i_cfg_index,
    input  logic [tes_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int DIV_W = $clog2(MAX_TAB_WIDTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_state;

    t_state                           r_state;
    logic [tes_pkg::CNT_W-1:0]        r_stop_count;
    logic [tes_pkg::CFG_W-1:0]        r_tab_width [tes_pkg::WIDTH_REGS];
    logic [tes_pkg::COL_W-1:0]        r_column;
    logic [tes_pkg::IDX_W-1:0]        r_stop_index;
    logic [DIV_W-1:0]                 r_width;
    logic [DIV_W-1:0]                 r_left;
    logic                             r_eol;
    logic                             r_out_valid;
    logic [tes_pkg::CHAR_W-1:0]       r_out_char;
    logic                             r_run_last;
    logic                             r_line_end_out;

    logic                             out_free;
    logic                             in_accept;
    logic                             is_tab;
    logic [tes_pkg::CNT_W-1:0]        live_count;
    logic [tes_pkg::IDX_W-1:0]        use_index;
    logic [tes_pkg::IDX_W-1:0]        next_index;
    logic [tes_pkg::CFG_W-1:0]        raw_width;
    logic [DIV_W-1:0]                 live_width;
    logic [DIV_W-1:0]                 space_count;
    logic [DIV_W-1:0]                 rem;
    logic                             rem_done;
    tes_pkg::t_rem_req                rem_req;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign is_tab     = (i_in_char == tes_pkg::CHAR_TAB);

    always_comb begin
        if (r_stop_count == '0) begin
            live_count = tes_pkg::CNT_W'(1);
        end else if (r_stop_count > tes_pkg::CNT_W'(tes_pkg::STOP_LIMIT)) begin
            live_count = tes_pkg::CNT_W'(tes_pkg::STOP_LIMIT);
        end else begin
            live_count = r_stop_count;
        end

        if ({1'b0, r_stop_index} >= live_count) begin
            use_index = '0;
        end else begin
            use_index = r_stop_index;
        end

        if (({1'b0, use_index} + 1'b1) >= live_count) begin
            next_index = '0;
        end else begin
            next_index = use_index + 1'b1;
        end

        raw_width = r_tab_width[use_index];
        if (raw_width == '0) begin
            live_width = DIV_W'(1);
        end else if (raw_width > tes_pkg::CFG_W'(MAX_TAB_WIDTH)) begin
            live_width = DIV_W'(MAX_TAB_WIDTH);
        end else begin
            live_width = DIV_W'(raw_width);
        end

        rem_req.start    = in_accept && is_tab;
        rem_req.dividend = r_column;
        space_count      = r_width - rem;
    end

    tes_rem_unit #(
        .DIV_W(DIV_W)
    ) u_rem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (rem_req),
        .i_divisor(live_width),
        .o_done   (rem_done),
        .o_rem    (rem)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_count <= tes_pkg::DEFAULT_COUNT;
            for (int i = 0; i < tes_pkg::WIDTH_REGS; i++) begin
                r_tab_width[i] <= tes_pkg::DEFAULT_WIDTH;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tes_pkg::REG_STOP_COUNT: begin
                    r_stop_count <= i_cfg_data[tes_pkg::CNT_W-1:0];
                end
                tes_pkg::REG_TAB_WIDTH_0: r_tab_width[0] <= i_cfg_data;
                tes_pkg::REG_TAB_WIDTH_1: r_tab_width[1] <= i_cfg_data;
                tes_pkg::REG_TAB_WIDTH_2: r_tab_width[2] <= i_cfg_data;
                tes_pkg::REG_TAB_WIDTH_3: r_tab_width[3] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_column     <= '0;
            r_stop_index <= '0;
            r_out_valid  <= 1'b0;
            r_left       <= '0;
            r_eol        <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_eol <= i_line_end;
                        if (is_tab) begin
                            r_width      <= live_width;
                            r_stop_index <= i_line_end ? '0 : next_index;
                            r_state      <= S_DIV;
                        end else begin
                            r_out_valid    <= 1'b1;
                            r_out_char     <= i_in_char;
                            r_run_last     <= 1'b1;
                            r_line_end_out <= i_line_end;
                            r_column       <= i_line_end ? '0 : r_column + 1'b1;
                            if (i_line_end) begin
                                r_stop_index <= '0;
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (rem_done) begin
                        r_left   <= space_count;
                        r_column <= r_eol ? '0 : r_column + tes_pkg::COL_W'(space_count);
                        r_state  <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out_char     <= tes_pkg::CHAR_SPACE;
                        r_run_last     <= (r_left == DIV_W'(1));
                        r_line_end_out <= r_eol && (r_left == DIV_W'(1));
                        r_left         <= r_left - 1'b1;
                        if (r_left == DIV_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_char     = r_out_char;
    assign o_run_last     = r_run_last;
    assign o_line_end_out = r_line_end_out;

    a_emit_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_left != '0))
        else $error("space run empty while emitting");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_done |-> (r_state == S_DIV))
        else $error("remainder finished outside divide state");

    a_eol_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_line_end_out) |-> r_run_last)
        else $error("line end flagged on a result that is not last");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |=> (r_state == S_DIV || r_state == S_EMIT))
        else $error("divide state left for an unexpected state");

endmodule

// ===== rtl/tes_rem_unit.sv =====
module tes_rem_unit #(
    parameter int DIV_W = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tes_pkg::t_rem_req          i_req,
    input  logic [DIV_W-1:0]           i_divisor,
    output logic                       o_done,
    output logic [DIV_W-1:0]           o_rem
);

    localparam int STEP_W = $clog2(tes_pkg::COL_W);

    logic                       r_busy;
    logic                       r_done;
    logic [STEP_W-1:0]          r_step;
    logic [tes_pkg::COL_W-1:0]  r_dividend;
    logic [DIV_W-1:0]           r_divisor;
    logic [DIV_W-1:0]           r_rem;
    logic [DIV_W:0]             shifted;
    logic [DIV_W-1:0]           n_rem;

    // one quotient bit a cycle, restoring
    always_comb begin
        shifted = {r_rem, r_dividend[tes_pkg::COL_W-1]};
        if (shifted >= {1'b0, r_divisor}) begin
            n_rem = DIV_W'(shifted - {1'b0, r_divisor});
        end else begin
            n_rem = shifted[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy     <= 1'b1;
                r_step     <= STEP_W'(tes_pkg::COL_W - 1);
                r_dividend <= i_req.dividend;
                r_divisor  <= i_divisor;
                r_rem      <= '0;
            end else if (r_busy) begin
                r_rem      <= n_rem;
                r_dividend <= {r_dividend[tes_pkg::COL_W-2:0], 1'b0};
                r_step     <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== test/tab_expander_stop_list_check.sv =====
module tab_expander_stop_list_check
    import tes_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [CHAR_W-1:0]    i_in_char,
    input  logic                 i_line_end,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [CHAR_W-1:0]    i_out_char,
    input  logic                 i_run_last,
    input  logic                 i_line_end_out,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              run_last;
        logic              line_end;
    } t_out_char;

    logic [CNT_W-1:0] stop_count = DEFAULT_COUNT;
    logic [CFG_W-1:0] tab_width [WIDTH_REGS];
    logic [COL_W-1:0] column = '0;
    logic [IDX_W-1:0] stop_index = '0;
    t_out_char        expected_chars [$];
    int               fail_count = 0;

    initial begin
        for (int k = 0; k < WIDTH_REGS; k++) begin
            tab_width[k] = DEFAULT_WIDTH;
        end
    end

    // one request: a byte passes through, a tab becomes a run of spaces
    task automatic expand_request(input logic [CHAR_W-1:0] ch, input logic eol);
        int        count;
        int        width;
        int        spaces;
        t_out_char res;
        if (ch == CHAR_TAB) begin
            count = (stop_count == 0) ? 1 : int'(stop_count);
            if (count > STOP_LIMIT) count = STOP_LIMIT;
            if (int'(stop_index) >= count) stop_index = '0;
            width = int'(tab_width[stop_index]);
            if (width < 1) width = 1;
            if (width > MAX_TAB_WIDTH) width = MAX_TAB_WIDTH;
            if (int'(stop_index) + 1 >= count) stop_index = '0;
            else stop_index = stop_index + 1'b1;
            spaces = width - (int'(column) % width);
            for (int k = 0; k < spaces; k++) begin
                res.ch       = CHAR_SPACE;
                res.run_last = (k == spaces - 1);
                res.line_end = eol && (k == spaces - 1);
                expected_chars.push_back(res);
            end
            column = column + COL_W'(spaces);
        end else begin
            res.ch       = ch;
            res.run_last = 1'b1;
            res.line_end = eol;
            expected_chars.push_back(res);
            column = column + 1'b1;
        end
        if (eol) begin
            column     = '0;
            stop_index = '0;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_char exp_char;
        if (!i_rst_n) begin
            stop_count = DEFAULT_COUNT;
            for (int k = 0; k < WIDTH_REGS; k++) begin
                tab_width[k] = DEFAULT_WIDTH;
            end
            column     = '0;
            stop_index = '0;
            expected_chars.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_STOP_COUNT:  stop_count   = i_cfg_data[CNT_W-1:0];
                    REG_TAB_WIDTH_0: tab_width[0] = i_cfg_data;
                    REG_TAB_WIDTH_1: tab_width[1] = i_cfg_data;
                    REG_TAB_WIDTH_2: tab_width[2] = i_cfg_data;
                    REG_TAB_WIDTH_3: tab_width[3] = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                expand_request(i_in_char, i_line_end);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_chars.size() == 0) begin
                    $display("%0t unexpected result: char %h run_last %b line_end %b",
                             $time, i_out_char, i_run_last, i_line_end_out);
                    fail_count++;
                end else begin
                    exp_char = expected_chars.pop_front();
                    if (i_out_char !== exp_char.ch) begin
                        $display("%0t out_char: expected %h actual %h",
                                 $time, exp_char.ch, i_out_char);
                        fail_count++;
                    end
                    if (i_run_last !== exp_char.run_last) begin
                        $display("%0t run_last: expected %b actual %b",
                                 $time, exp_char.run_last, i_run_last);
                        fail_count++;
                    end
                    if (i_line_end_out !== exp_char.line_end) begin
                        $display("%0t line_end_out: expected %b actual %b",
                                 $time, exp_char.line_end, i_line_end_out);
                        fail_count++;
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_chars.size();
    end

endmodule

// ===== test/tab_expander_stop_list_test.sv =====
module tab_expander_stop_list_test;
    import tes_pkg::*;

    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 90;
    localparam int DRAIN_CYCLES  = 100;
    localparam int BLOCK_ITEMS   = 30;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [CHAR_W-1:0]    i_in_char = '0;
    logic                 i_line_end = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [CHAR_W-1:0]    o_out_char;
    logic                 o_run_last;
    logic                 o_line_end_out;
    logic                 i_cfg_we = 1'b0;
    logic [REG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    int fail_count;
    int pending_chars;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int sent_count = 0;
    int quiet_cycles = 0;

    tab_expander_stop_list i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_char      (i_in_char),
        .i_line_end     (i_line_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_char     (o_out_char),
        .o_run_last     (o_run_last),
        .o_line_end_out (o_line_end_out),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    tab_expander_stop_list_check i_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_in_char      (i_in_char),
        .i_line_end     (i_line_end),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out_char     (o_out_char),
        .i_run_last     (o_run_last),
        .i_line_end_out (o_line_end_out),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending_chars)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input logic [CHAR_W-1:0] ch, input logic eol);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_char  <= ch;
        i_line_end <= eol;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent_count++;
    endtask

    // drop valid and wait until every expected character has come out
    task automatic wait_idle(input int extra);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_chars != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic load_stops(input logic [CFG_W-1:0] count, input logic [CFG_W-1:0] w0,
                              input logic [CFG_W-1:0] w1, input logic [CFG_W-1:0] w2,
                              input logic [CFG_W-1:0] w3);
        cfg_write(REG_STOP_COUNT, count);
        cfg_write(REG_TAB_WIDTH_0, w0);
        cfg_write(REG_TAB_WIDTH_1, w1);
        cfg_write(REG_TAB_WIDTH_2, w2);
        cfg_write(REG_TAB_WIDTH_3, w3);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] pick_width();
        case ($urandom_range(9))
            0:       return '0;
            1:       return CFG_W'(1);
            2:       return CFG_W'(MAX_TAB_WIDTH);
            3:       return CFG_W'($urandom_range(MAX_TAB_WIDTH + 1, 127));
            default: return CFG_W'($urandom_range(2, 12));
        endcase
    endfunction

    task automatic send_line(input int len);
        logic [CHAR_W-1:0] ch;
        for (int k = 0; k < len; k++) begin
            ch = ($urandom_range(3) == 0) ? CHAR_TAB : CHAR_W'($urandom_range(32, 126));
            send_request(ch, k == len - 1);
        end
    endtask

    task automatic run_block(input int items);
        int first;
        first = sent_count;
        while (sent_count - first < items) begin
            if ($urandom_range(7) == 0) begin
                send_request(CHAR_W'($urandom_range(255)), $urandom_range(9) == 0);
            end else begin
                send_line($urandom_range(1, 10));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct  = 30;
        recv_stall_pct = 67;

        // reset widths: plain bytes, tabs from columns 2 and 4, tab on a line end
        send_request(8'h00, 1'b0);
        send_request(8'hff, 1'b0);
        send_request(CHAR_TAB, 1'b0);
        send_request(CHAR_TAB, 1'b0);
        send_request(8'h41, 1'b1);
        send_request(CHAR_TAB, 1'b1);

        // count saturated, widths zero and above the maximum
        wait_idle(SETTLE_CYCLES);
        load_stops(7'h7f, 7'd0, 7'd1, 7'd64, 7'd127);
        send_request(8'h78, 1'b0);
        send_request(CHAR_TAB, 1'b0);
        send_request(CHAR_TAB, 1'b0);
        send_request(CHAR_TAB, 1'b0);

        // count lowered mid-line leaves the index past the end; unknown indexes ignored
        wait_idle(SETTLE_CYCLES);
        cfg_write(REG_STOP_COUNT, 7'd2);
        cfg_write(3'd5, 7'h7f);
        cfg_write(3'd6, 7'h7f);
        cfg_write(3'd7, 7'h7f);
        i_cfg_we <= 1'b0;
        send_request(CHAR_TAB, 1'b0);
        send_request(CHAR_TAB, 1'b1);

        // count of zero in the low bits
        wait_idle(SETTLE_CYCLES);
        cfg_write(REG_STOP_COUNT, 7'b1111000);
        i_cfg_we <= 1'b0;
        send_request(CHAR_TAB, 1'b0);
        send_request(CHAR_TAB, 1'b1);

        for (int phase = 0; phase < 3; phase++) begin
            for (int blk = 0; blk < 4; blk++) begin
                wait_idle(SETTLE_CYCLES);
                send_idle_pct  = (phase == 0) ? 30 : (phase == 1) ? 67 : 0;
                recv_stall_pct = (phase == 0) ? 67 : (phase == 1) ? 30 : 0;
                load_stops({4'($urandom_range(15)), 3'($urandom_range(7))},
                           pick_width(), pick_width(), pick_width(), pick_width());
                run_block(BLOCK_ITEMS);
            end
        end

        wait_idle(DRAIN_CYCLES);
        if (fail_count == 0 && pending_chars == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== tab_expander_stop_list.f =====
rtl/tes_pkg.sv
rtl/tes_rem_unit.sv
rtl/tab_expander_stop_list.sv
test/tab_expander_stop_list_check.sv
test/tab_expander_stop_list_test.sv
